/* sv/ofsd_pkg.sv */
package ofsd_pkg;

    localparam int BYTE_W = 8;
    localparam int WORD_W = 16;
    localparam int KIND_W = 2;

    localparam logic [WORD_W-1:0] HDR_WORDS_A = 16'hCADE;
    localparam logic [WORD_W-1:0] HDR_WORDS_B = 16'hDADA;

    localparam logic [KIND_W-1:0] KIND_WORD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] word;
        logic [BYTE_W-1:0] ch;
        logic              last;
    } ofsd_result_t;

endpackage

/* sv/ofsd_parser.sv */
module ofsd_parser
    import ofsd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_accept,
    input  logic [BYTE_W-1:0] byte_in,
    output ofsd_result_t      result
);

    localparam logic [2:0] PH_HDR_HI  = 3'd0;
    localparam logic [2:0] PH_HDR_LO  = 3'd1;
    localparam logic [2:0] PH_ADDR_HI = 3'd2;
    localparam logic [2:0] PH_ADDR_LO = 3'd3;
    localparam logic [2:0] PH_CNT_HI  = 3'd4;
    localparam logic [2:0] PH_CNT_LO  = 3'd5;
    localparam logic [2:0] PH_BODY    = 3'd6;
    localparam logic [2:0] PH_WORD_LO = 3'd7;

    logic [2:0]        phase_reg, phase_next;
    logic [BYTE_W-1:0] hold_reg, hold_next;
    logic              is_word_reg, is_word_next;
    logic [WORD_W-1:0] addr_reg, addr_next;
    logic [WORD_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0] joined;
    logic [WORD_W-1:0] cnt_dec;

    assign joined  = {hold_reg, byte_in};
    assign cnt_dec = cnt_reg - WORD_W'(1);

    always_comb begin
        phase_next   = phase_reg;
        hold_next    = hold_reg;
        is_word_next = is_word_reg;
        addr_next    = addr_reg;
        cnt_next     = cnt_reg;
        result       = '0;
        result.addr  = addr_reg;
        unique case (phase_reg)
            PH_HDR_HI, PH_ADDR_HI, PH_CNT_HI: begin
                hold_next  = byte_in;
                phase_next = phase_reg + 3'd1;
            end
            PH_HDR_LO: begin
                is_word_next = (joined == HDR_WORDS_A) || (joined == HDR_WORDS_B);
                phase_next   = PH_ADDR_HI;
            end
            PH_ADDR_LO: begin
                addr_next  = joined;
                phase_next = PH_CNT_HI;
            end
            PH_CNT_LO: begin
                cnt_next = joined;
                if (joined != '0) begin
                    phase_next = PH_BODY;
                end else begin
                    phase_next = PH_HDR_HI;
                    // empty label still reports its address
                    if (!is_word_reg) begin
                        result.valid = 1'b1;
                        result.kind  = KIND_EMPTY;
                        result.last  = 1'b1;
                    end
                end
            end
            PH_BODY: begin
                if (is_word_reg) begin
                    hold_next  = byte_in;
                    phase_next = PH_WORD_LO;
                end else begin
                    result.valid = 1'b1;
                    result.kind  = KIND_CHAR;
                    result.ch    = byte_in;
                    result.last  = (cnt_dec == '0);
                    cnt_next     = cnt_dec;
                    phase_next   = (cnt_dec == '0) ? PH_HDR_HI : PH_BODY;
                end
            end
            PH_WORD_LO: begin
                result.valid = 1'b1;
                result.kind  = KIND_WORD;
                result.word  = joined;
                addr_next    = addr_reg + WORD_W'(1);
                cnt_next     = cnt_dec;
                phase_next   = (cnt_dec == '0) ? PH_HDR_HI : PH_BODY;
            end
            default: begin
                phase_next = PH_HDR_HI;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HDR_HI;
            hold_reg    <= '0;
            is_word_reg <= 1'b0;
            addr_reg    <= '0;
            cnt_reg     <= '0;
        end else if (byte_accept) begin
            phase_reg   <= phase_next;
            hold_reg    <= hold_next;
            is_word_reg <= is_word_next;
            addr_reg    <= addr_next;
            cnt_reg     <= cnt_next;
        end
    end

endmodule

/* sv/object_file_section_deframer.sv */
// channel  | dir | beat contents
// s_       | in  | tdata[7:0] in_byte
// m_       | out | tdata target_address, word_value, label_char; tuser result_kind;
//          |     | tlast label_last
// one input byte per cycle while s_tready is high; a result appears in the output
// register the cycle after its byte is taken, and the parse state loop sets the
// one-byte-per-cycle rate
// synchronous active-low reset returns the parser to the header high byte
// a stalled result holds s_tready low only while m_tready is low
module object_file_section_deframer
    import ofsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // target_address, word_value, label_char
    output logic [1:0]  m_tuser,   // result_kind
    output logic        m_tlast    // label_last
);

    ofsd_result_t      result;
    logic              accept;
    logic              m_valid_reg;
    logic [39:0]       m_data_reg;
    logic [KIND_W-1:0] m_user_reg;
    logic              m_last_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    ofsd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (accept),
        .byte_in     (s_tdata),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                m_valid_reg <= result.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {result.ch, result.word, result.addr};
            m_user_reg <= result.kind;
            m_last_reg <= result.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule
